/* src/rdw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdw_pkg: shared types and constants for the replay dedup window
// Entry layout, per-cell match flags, verdict codes and controller states.
// ----------------------------------------------------------------------------
package rdw_pkg;

    localparam int DEFAULT_CAPACITY = 16;

    localparam int ID_W      = 64;
    localparam int DIG_W     = 64;
    localparam int WS_W      = 5;
    localparam int HELD_W    = 5;
    localparam int VERDICT_W = 3;

    localparam logic [WS_W-1:0] WS_RESET = WS_W'(16);

    typedef enum logic [VERDICT_W-1:0] {
        V_FRESH    = 3'd0,
        V_REPLAY   = 3'd1,
        V_CONFLICT = 3'd2,
        V_INVALID  = 3'd3,
        V_CLEARED  = 3'd4
    } verdict_t;

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [DIG_W-1:0] d3;
        logic [DIG_W-1:0] d2;
        logic [DIG_W-1:0] d1;
        logic [DIG_W-1:0] d0;
    } entry_t;

    typedef struct packed {
        logic hit;
        logic same;
    } cell_flags_t;

endpackage

/* src/replay_dedup_window_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// replay_dedup_window_core: bounded replay window for attempt identifiers
// Request words carry a mode, an identifier and a 256-bit digest; each
// request returns one response word with a verdict and the entry count.
//
// Usage:
//   - request channel req_valid/req_ready, response channel rsp_valid/rsp_ready
//   - cfg_we writes window_size from cfg_wdata; the user must write it only
//     while the block is idle, the block itself does not enforce this
//   - in the accept cycle every slot compares the word against its own entry
//     and registers the result; when the response slot is free the flags are
//     reduced, the verdict is formed and a fresh identifier shifts the slot
//     chain by one, entering slot 0; one request in flight at a time
//   - response is registered; req_ready is high in idle even while a response
//     waits, the evaluate step then holds until the response slot frees up
//   - reset empties the window and sets window_size to 16; slot contents
//     are not cleared, the entry count masks stale slots
// ----------------------------------------------------------------------------
module replay_dedup_window_core
    import rdw_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [WS_W-1:0]      cfg_wdata,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic                 mode,
    input  logic [ID_W-1:0]      attempt_id,
    input  logic [DIG_W-1:0]     digest_word0,
    input  logic [DIG_W-1:0]     digest_word1,
    input  logic [DIG_W-1:0]     digest_word2,
    input  logic [DIG_W-1:0]     digest_word3,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [VERDICT_W-1:0] verdict,
    output logic [HELD_W-1:0]    entries_held
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > WS_W) ? CNT_W : WS_W;

    state_t               state_reg, state_next;
    logic [WS_W-1:0]      ws_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    entry_t               query;
    entry_t               query_reg;
    logic                 mode_reg;
    logic                 id_zero_reg;
    logic                 rsp_valid_reg, rsp_valid_next;
    verdict_t             verdict_reg, verdict_next;
    logic [HELD_W-1:0]    held_reg, held_next;

    logic                 accept;
    logic                 fire;
    logic                 shift_en;
    logic                 any_hit;
    logic                 any_same;
    logic                 evict;
    logic [CMP_W-1:0]     count_ext;
    logic [CMP_W-1:0]     ws_ext;
    logic [CMP_W-1:0]     limit;

    entry_t               chain [CAPACITY];
    cell_flags_t          flags [CAPACITY];
    logic [CAPACITY-1:0]  hit_vec;
    logic [CAPACITY-1:0]  same_vec;

    assign query.id = attempt_id;
    assign query.d0 = digest_word0;
    assign query.d1 = digest_word1;
    assign query.d2 = digest_word2;
    assign query.d3 = digest_word3;

    assign accept = req_valid && req_ready;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            entry_t prev;
            logic   live;

            if (gi == 0)
            begin : g_head
                assign prev = query_reg;
            end
            else
            begin : g_body
                assign prev = chain[gi-1];
            end

            // slots below the count hold live entries, newest at slot 0
            assign live = (CNT_W'(gi) < count_reg);

            rdw_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .capture    (accept),
                .shift      (shift_en),
                .live       (live),
                .query      (query),
                .prev_entry (prev),
                .entry      (chain[gi]),
                .flags      (flags[gi])
            );

            assign hit_vec[gi]  = flags[gi].hit;
            assign same_vec[gi] = flags[gi].same;
        end
    endgenerate

    // live identifiers are unique, so at most one slot can hit
    assign any_hit  = |hit_vec;
    assign any_same = |same_vec;

    assign count_ext = CMP_W'(count_reg);
    assign ws_ext    = CMP_W'(ws_reg);

    always_comb
    begin
        if (ws_ext == '0)
        begin
            limit = CMP_W'(1);
        end
        else if (ws_ext > CMP_W'(CAPACITY))
        begin
            limit = CMP_W'(CAPACITY);
        end
        else
        begin
            limit = ws_ext;
        end
    end

    // with the window lowered below the count, only one entry goes out
    assign evict = (count_ext >= limit);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        verdict_next   = verdict_reg;
        held_next      = held_reg;
        fire           = 1'b0;
        shift_en       = 1'b0;
        req_ready      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    fire = 1'b1;
                    if (mode_reg)
                    begin
                        verdict_next = V_CLEARED;
                        count_next   = '0;
                    end
                    else if (id_zero_reg)
                    begin
                        verdict_next = V_INVALID;
                    end
                    else if (any_hit)
                    begin
                        verdict_next = any_same ? V_REPLAY : V_CONFLICT;
                    end
                    else
                    begin
                        verdict_next = V_FRESH;
                        shift_en     = 1'b1;
                        if (!evict)
                        begin
                            count_next = CNT_W'(count_reg + 1'b1);
                        end
                    end
                    held_next      = HELD_W'(count_next);
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ws_reg        <= WS_RESET;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            mode_reg      <= 1'b0;
            id_zero_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                ws_reg <= cfg_wdata;
            end
            if (accept)
            begin
                mode_reg    <= mode;
                id_zero_reg <= (attempt_id == '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            query_reg <= query;
        end
        if (fire)
        begin
            verdict_reg <= verdict_next;
            held_reg    <= held_next;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign verdict      = verdict_reg;
    assign entries_held = held_reg;

endmodule

/* src/rdw_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdw_cell: one slot of the window
// Holds one identifier with its digest, compares it against the incoming
// word and hands its entry to the next older slot on insert.
// ----------------------------------------------------------------------------
module rdw_cell
    import rdw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        capture,
    input  logic        shift,
    input  logic        live,
    input  entry_t      query,
    input  entry_t      prev_entry,
    output entry_t      entry,
    output cell_flags_t flags
);

    entry_t      entry_reg;
    cell_flags_t flags_reg;
    cell_flags_t flags_next;

    always_comb
    begin
        flags_next.hit  = live && (entry_reg.id == query.id);
        flags_next.same = flags_next.hit &&
                          (entry_reg.d0 == query.d0) && (entry_reg.d1 == query.d1) &&
                          (entry_reg.d2 == query.d2) && (entry_reg.d3 == query.d3);
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_reg <= prev_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (capture)
        begin
            flags_reg <= flags_next;
        end
    end

    assign entry = entry_reg;
    assign flags = flags_reg;

endmodule

/* src/rdw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdw_checker: port-level checks for the replay dedup window
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module rdw_checker
    import rdw_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic [VERDICT_W-1:0] verdict,
    input logic [HELD_W-1:0]    entries_held
);

    // one request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted back to back");

    // a new response word must trace back to an accepted request
    a_rsp_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("response word without matching request");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (verdict <= V_CLEARED))
        else $error("verdict code out of range");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && verdict == V_CLEARED) |-> (entries_held == '0))
        else $error("clear left entries in the window");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(verdict) && $stable(entries_held)))
        else $error("stalled response word changed");

endmodule

bind replay_dedup_window_core rdw_checker u_rdw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .verdict      (verdict),
    .entries_held (entries_held)
);
